/* hw/rtl/jpdt_pkg.sv */
// Shared types and constants for the joint PD torque block.
`timescale 1ns / 1ps
`default_nettype none
package jpdt_pkg;

  // Angle wrap constants, Q4.12
  localparam int PI_Q12     = 12868;
  localparam int TWO_PI_Q12 = 25736;

  // Hold gains, Q8.8 (40.0 and 2.0)
  localparam logic [15:0] HOLD_KP = 16'd10240;
  localparam logic [15:0] HOLD_KD = 16'd512;

  // Joint kind codes
  localparam logic [1:0] KIND_ABAD = 2'd0;
  localparam logic [1:0] KIND_HIP  = 2'd1;
  localparam logic [1:0] KIND_KNEE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_LIMIT_ABAD = 2'd0;
  localparam logic [1:0] REG_LIMIT_HIP  = 2'd1;
  localparam logic [1:0] REG_LIMIT_KNEE = 2'd2;

  localparam logic [14:0] LIMIT_RESET = 15'h7FFF;

  // Sit posture angle per joint kind, Q4.12; the unused fourth kind sits as a knee
  localparam logic signed [15:0] SIT_ANGLE [4] = '{
    16'sd0, 16'sd5571, -16'sd10854, -16'sd10854
  };

  // Input item as registered at the slave side
  typedef struct packed {
    logic [1:0]         kind;
    logic               cmd_valid;
    logic signed [15:0] meas_ang;
    logic signed [15:0] meas_rate;
    logic signed [15:0] tgt_ang;
    logic signed [15:0] tgt_rate;
    logic [15:0]        kp;
    logic [15:0]        kd;
    logic signed [15:0] ff;
  } in_t;

  // Errors and selected gains
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [14:0] ang_err;
    logic signed [16:0] rate_err;
    logic [15:0]        kp;
    logic [15:0]        kd;
    logic signed [15:0] ff;
  } err_t;

  // Partial torque products
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] p_term;
    logic signed [33:0] d_term;
    logic signed [15:0] ff;
  } prod_t;

  // Result item
  typedef struct packed {
    logic signed [15:0] torque;
    logic               limited;
  } res_t;

endpackage
`default_nettype wire

/* hw/rtl/joint_pd_torque_with_hold.sv */
// Top level of the joint PD torque block: item pipeline and limit registers.
// Usage:
//   Slave channel s_*: one joint sample per item. s_tuser carries the joint kind
//   and the command-valid flag; s_tdata carries angles, rates, gains and
//   feedforward. Without a valid command the joint holds its sit posture.
//   Master channel m_*: one clamped torque per item, with the clamp flag in m_tuser.
//   Configuration: cfg_we writes cfg_data into limit register cfg_index
//   (0 abduction, 1 hip, 2 knee); index 3 is ignored. Write only while idle.
// Timing:
//   Four register stages (input, error, product, result); the result of an
//   item shows on m_tvalid once it has passed all four. One item per cycle is
//   accepted and delivered while m_tready is high; the two multipliers in the
//   product stage set the cycle time.
// Reset: rst empties the pipeline and sets all limits to full scale (32767).
// Stall: when m_tready is low the result holds; earlier stages keep filling
//   any empty slot, so s_tready drops only once every stage is occupied.
`timescale 1ns / 1ps
`default_nettype none
module joint_pd_torque_with_hold (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [15:0] measured_angle, [31:16] measured_rate, [47:32] target_angle,
  // [63:48] target_rate, [79:64] gain_p, [95:80] gain_d, [111:96] feedforward
  input  logic [111:0] s_tdata,
  // [1:0] motor_kind, [2] command_valid
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [15:0] drive_torque
  output logic [15:0]  m_tdata,
  // [0] was_limited
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [14:0]  cfg_data
);
  import jpdt_pkg::*;

  logic [14:0] limit_abad;
  logic [14:0] limit_hip;
  logic [14:0] limit_knee;
  logic [14:0] limit_sel;

  in_t   in_reg;
  err_t  err_reg;
  prod_t prod_reg;
  res_t  res_reg;
  err_t  err_next;
  prod_t prod_next;
  res_t  res_next;

  logic v_in, v_err, v_prod, v_res;
  logic en_in, en_err, en_prod, en_res;

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_abad <= LIMIT_RESET;
      limit_hip  <= LIMIT_RESET;
      limit_knee <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIMIT_ABAD: limit_abad <= cfg_data;
        REG_LIMIT_HIP:  limit_hip  <= cfg_data;
        REG_LIMIT_KNEE: limit_knee <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its contents move on
  assign en_res  = !v_res  || m_tready;
  assign en_prod = !v_prod || en_res;
  assign en_err  = !v_err  || en_prod;
  assign en_in   = !v_in   || en_err;
  assign s_tready = en_in;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in   <= 1'b0;
      v_err  <= 1'b0;
      v_prod <= 1'b0;
      v_res  <= 1'b0;
    end else begin
      if (en_in)   v_in   <= s_tvalid;
      if (en_err)  v_err  <= v_in;
      if (en_prod) v_prod <= v_err;
      if (en_res)  v_res  <= v_prod;
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (en_in) begin
      in_reg.kind      <= s_tuser[1:0];
      in_reg.cmd_valid <= s_tuser[2];
      in_reg.meas_ang  <= s_tdata[15:0];
      in_reg.meas_rate <= s_tdata[31:16];
      in_reg.tgt_ang   <= s_tdata[47:32];
      in_reg.tgt_rate  <= s_tdata[63:48];
      in_reg.kp        <= s_tdata[79:64];
      in_reg.kd        <= s_tdata[95:80];
      in_reg.ff        <= s_tdata[111:96];
    end
  end

  jpdt_err u_err (
    .item (in_reg),
    .err  (err_next)
  );

  always_ff @(posedge clk) begin
    if (en_err) err_reg <= err_next;
  end

  jpdt_mul u_mul (
    .err  (err_reg),
    .prod (prod_next)
  );

  always_ff @(posedge clk) begin
    if (en_prod) prod_reg <= prod_next;
  end

  // Limit for the joint kind; the fourth kind uses the knee limit
  always_comb begin
    case (prod_reg.kind)
      KIND_ABAD: limit_sel = limit_abad;
      KIND_HIP:  limit_sel = limit_hip;
      default:   limit_sel = limit_knee;
    endcase
  end

  jpdt_clamp u_clamp (
    .prod  (prod_reg),
    .limit (limit_sel),
    .res   (res_next)
  );

  always_ff @(posedge clk) begin
    if (en_res) res_reg <= res_next;
  end

  assign m_tvalid = v_res;
  assign m_tdata  = res_reg.torque;
  assign m_tuser  = res_reg.limited;

endmodule
`default_nettype wire

/* hw/rtl/jpdt_err.sv */
// Command or hold selection, wrapped angle error and rate error.
`timescale 1ns / 1ps
`default_nettype none
module jpdt_err (
  input  jpdt_pkg::in_t  item,
  output jpdt_pkg::err_t err
);
  import jpdt_pkg::*;

  logic signed [15:0] tgt_ang;
  logic signed [15:0] tgt_rate;
  logic [15:0]        kp_sel;
  logic [15:0]        kd_sel;
  logic signed [15:0] ff_sel;
  logic signed [16:0] diff;
  logic signed [18:0] shifted;
  logic signed [18:0] wrapped;

  // Pick the command or the sit posture
  always_comb begin
    if (item.cmd_valid) begin
      tgt_ang  = item.tgt_ang;
      tgt_rate = item.tgt_rate;
      kp_sel   = item.kp;
      kd_sel   = item.kd;
      ff_sel   = item.ff;
    end else begin
      tgt_ang  = SIT_ANGLE[item.kind];
      tgt_rate = '0;
      kp_sel   = HOLD_KP;
      kd_sel   = HOLD_KD;
      ff_sel   = '0;
    end
  end

  assign diff    = 17'(tgt_ang) - 17'(item.meas_ang);
  assign shifted = 19'(diff) + 19'(PI_Q12);

  // Reduce modulo two pi: at most three turns either way, try each in parallel
  always_comb begin
    logic signed [18:0] cand;
    wrapped = '0;
    for (int k = 0; k < 7; k++) begin
      cand = shifted + 19'((k - 3) * TWO_PI_Q12);
      if (cand >= 19'sd0 && cand < 19'(TWO_PI_Q12)) begin
        wrapped = cand;
      end
    end
  end

  // Pack the errors and the selected gains
  always_comb begin
    err.kind     = item.kind;
    err.ang_err  = 15'(wrapped - 19'(PI_Q12));
    err.rate_err = 17'(tgt_rate) - 17'(item.meas_rate);
    err.kp       = kp_sel;
    err.kd       = kd_sel;
    err.ff       = ff_sel;
  end

endmodule
`default_nettype wire

/* hw/rtl/jpdt_mul.sv */
// Proportional and derivative products.
`timescale 1ns / 1ps
`default_nettype none
module jpdt_mul (
  input  jpdt_pkg::err_t  err,
  output jpdt_pkg::prod_t prod
);
  import jpdt_pkg::*;

  // Gains are unsigned; widen with a zero sign bit
  assign prod.p_term = 32'($signed({1'b0, err.kp})) * 32'(err.ang_err);
  assign prod.d_term = 34'($signed({1'b0, err.kd})) * 34'(err.rate_err);
  assign prod.kind   = err.kind;
  assign prod.ff     = err.ff;

endmodule
`default_nettype wire

/* hw/rtl/jpdt_clamp.sv */
// Torque sum, rounding to Q8.8 and symmetric clamp.
`timescale 1ns / 1ps
`default_nettype none
module jpdt_clamp (
  input  jpdt_pkg::prod_t prod,
  input  logic [14:0]     limit,
  output jpdt_pkg::res_t  res
);
  import jpdt_pkg::*;

  logic signed [37:0] sum;
  logic signed [25:0] raw;
  logic signed [25:0] pos_lim;
  logic signed [25:0] neg_lim;

  // Sum with 20 fraction bits, add one half and floor to 8 fraction bits
  assign sum = 38'(prod.p_term) + (38'(prod.d_term) <<< 4) + (38'(prod.ff) <<< 12)
             + 38'sd2048;
  assign raw = sum[37:12];

  assign pos_lim = $signed({11'd0, limit});
  assign neg_lim = -pos_lim;

  // Clamp to +-limit and flag it
  always_comb begin
    if (raw > pos_lim) begin
      res.torque  = 16'(pos_lim);
      res.limited = 1'b1;
    end else if (raw < neg_lim) begin
      res.torque  = 16'(neg_lim);
      res.limited = 1'b1;
    end else begin
      res.torque  = 16'(raw);
      res.limited = 1'b0;
    end
  end

endmodule
`default_nettype wire
